/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the sequencer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// expr must hold at every clock edge outside reset
`define ASSERT_ALWAYS(name, clk, rst, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
// cond at one edge implies expr at the same edge
`define ASSERT_IMPLIES(name, clk, rst, cond, expr) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed");
`else
`define ASSERT_ALWAYS(name, clk, rst, expr)
`define ASSERT_IMPLIES(name, clk, rst, cond, expr)
`endif

`endif

/* hw/rtl/fesq_pkg.sv */
// Types, constants and step decoding for the flash erase/program sequencer.
`default_nettype none
package fesq_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_BYTE  = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_STATUS = 2'd2;

  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_ERASE_DONE   = 3'd1;
  localparam logic [2:0] EV_VERIFIED     = 3'd2;
  localparam logic [2:0] EV_PROG_RETRY   = 3'd3;
  localparam logic [2:0] EV_VERIFY_RETRY = 3'd4;
  localparam logic [2:0] EV_ERASE_RETRY  = 3'd5;
  localparam logic [2:0] EV_IMAGE_END    = 3'd6;

  localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
  localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
  localparam logic [7:0] CMD_PROGRAM = 8'hA0;
  localparam logic [7:0] CMD_ERASE   = 8'h80;
  localparam logic [7:0] CMD_SECTOR  = 8'h30;
  localparam logic [7:0] CMD_RESET   = 8'hF0;
  localparam logic [7:0] BLANK_BYTE  = 8'hFF;
  localparam logic [7:0] DQ5_MASK    = 8'h20;
  localparam logic [7:0] LIMIT_RESET = 8'd20;
  localparam logic [7:0] RUN_MAX     = 8'hFF;

  localparam logic [15:0] ADDR_555 = 16'h0555;
  localparam logic [15:0] ADDR_2AA = 16'h02AA;

  typedef enum logic [3:0] {
    PH_IDLE, PH_ERASE_FIRST, PH_ERASE_POLL, PH_ERASE_RECHECK, PH_READY,
    PH_PROG_POLL, PH_PROG_RECHECK, PH_VERIFY, PH_DONE
  } phase_t;

  // Result sequences the back end knows how to play out.
  typedef enum logic [2:0] {
    SEQ_ERASE, SEQ_PROG, SEQ_VERIFY, SEQ_READ, SEQ_STATUS
  } seq_t;

  typedef struct packed {
    seq_t        seq;
    logic [2:0]  start;
    logic [2:0]  stop;
    logic [2:0]  first_ev;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [15:0] count;
  } job_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [2:0]  ev;
  } bus_t;

  // One result of a sequence. Event here is the one carried on steps past
  // the first; the first step takes the job's own event.
  function automatic bus_t seq_step(input seq_t seq, input logic [2:0] step,
                                    input logic [15:0] addr, input logic [7:0] data);
    bus_t r;
    r = '{op: OP_WRITE, addr: 16'd0, data: 8'd0, ev: EV_NONE};
    case (seq)
      SEQ_ERASE: begin
        case (step)
          3'd0: r.data = CMD_RESET;
          3'd1: begin r.addr = ADDR_555; r.data = CMD_UNLOCK1; end
          3'd2: begin r.addr = ADDR_2AA; r.data = CMD_UNLOCK2; end
          3'd3: begin r.addr = ADDR_555; r.data = CMD_ERASE;   end
          3'd4: begin r.addr = ADDR_555; r.data = CMD_UNLOCK1; end
          3'd5: begin r.addr = ADDR_2AA; r.data = CMD_UNLOCK2; end
          3'd6: r.data = CMD_SECTOR;
          default: r.op = OP_READ;
        endcase
      end
      SEQ_PROG: begin
        case (step)
          3'd0: begin r.addr = addr; r.data = CMD_RESET; end
          3'd1: r.data = CMD_RESET;
          3'd2: begin r.addr = ADDR_555; r.data = CMD_UNLOCK1; end
          3'd3: begin r.addr = ADDR_2AA; r.data = CMD_UNLOCK2; end
          3'd4: begin r.addr = ADDR_555; r.data = CMD_PROGRAM; end
          3'd5: begin r.addr = addr; r.data = data; end
          default: begin r.op = OP_READ; r.addr = addr; end
        endcase
      end
      SEQ_VERIFY: begin
        r.addr = addr;
        if (step == 3'd0) begin
          r.data = CMD_RESET;
        end else begin
          r.op = OP_READ;
        end
      end
      SEQ_READ: begin
        r.op   = OP_READ;
        r.addr = addr;
      end
      default: begin
        r.op = OP_STATUS;
        if (step != 3'd0) begin
          r.ev = EV_IMAGE_END;
        end
      end
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/flash_erase_program_sequencer_unit.sv */
// Top level of the JEDEC parallel flash erase/program sequencer.
//
//  channel | signals                          | direction | carries
//  --------+----------------------------------+-----------+--------------------------
//  in      | in_valid, in_stall, kind, value  | into unit | start, image byte, read data
//  out     | out_valid, out_stall, op, ...    | from unit | bus write/read, status
//  cfg     | cfg_we, cfg_data                 | into unit | blank_run_limit
//
// An item is taken whenever in_valid is high and in_stall is low; the front end
// updates the phase at once and, unless it drops the item, posts a job into a
// four-entry queue. The back end plays a job out through its output register
// at one result per cycle while out_stall is low, 1 to 8 results per item.
// in_stall rises only while the job queue is full; out_stall holds the
// output register. rst is synchronous and clears phase, counters and queue;
// blank_run_limit returns to 20.
`default_nettype none
module flash_erase_program_sequencer_unit import fesq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       op,
  output logic [15:0]      flash_address,
  output logic [7:0]       write_data,
  output logic [2:0]       event_res,
  output logic [15:0]      verified_count,
  output logic             last
);

  logic accept;
  logic push, pop, q_full, q_nonempty;
  job_t push_job, q_head;

  // items wait only on queue space, never on the output side directly
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  fesq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .accept   (accept),
    .kind     (kind),
    .value    (value),
    .push     (push),
    .job      (push_job)
  );

  fesq_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (q_head)
  );

  fesq_back u_back (
    .clk            (clk),
    .rst            (rst),
    .q_nonempty     (q_nonempty),
    .q_head         (q_head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .op             (op),
    .flash_address  (flash_address),
    .write_data     (write_data),
    .event_res      (event_res),
    .verified_count (verified_count),
    .last           (last)
  );

endmodule
`default_nettype wire

/* hw/rtl/fesq_front.sv */
// Front end: takes items, tracks the sequencer phase and posts jobs.
`default_nettype none
module fesq_front import fesq_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        accept,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  value,
  output logic             push,
  output job_t             job
);

  logic [7:0]  blank_run_limit;
  phase_t      phase, phase_next;
  logic [15:0] next_address, next_address_next;
  logic [7:0]  pending_byte, pending_byte_next;
  logic [7:0]  blank_run, blank_run_next;
  logic [15:0] good_bytes, good_bytes_next;
  logic        post;

  always_comb begin
    phase_next        = phase;
    next_address_next = next_address;
    pending_byte_next = pending_byte;
    blank_run_next    = blank_run;
    good_bytes_next   = good_bytes;
    post              = 1'b0;
    job = '{seq: SEQ_READ, start: 3'd0, stop: 3'd0, first_ev: EV_NONE,
            addr: 16'd0, data: 8'd0, count: good_bytes};
    case (kind)
      KIND_START: begin
        next_address_next = 16'd0;
        blank_run_next    = 8'd0;
        good_bytes_next   = 16'd0;
        post              = 1'b1;
        job.seq   = SEQ_ERASE;
        job.start = 3'd1;
        job.stop  = 3'd7;
        job.count = 16'd0;
        phase_next = PH_ERASE_FIRST;
      end
      KIND_BYTE: begin
        if (phase == PH_READY) begin
          if (value == BLANK_BYTE) begin
            if (blank_run != RUN_MAX) blank_run_next = blank_run + 8'd1;
          end else begin
            blank_run_next = 8'd0;
          end
          pending_byte_next = value;
          post      = 1'b1;
          job.seq   = SEQ_PROG;
          job.start = 3'd1;
          job.stop  = 3'd6;
          job.addr  = next_address;
          job.data  = value;
          phase_next = PH_PROG_POLL;
        end
      end
      KIND_READ: begin
        job.addr = next_address;
        job.data = pending_byte;
        case (phase)
          PH_ERASE_FIRST: begin
            post = 1'b1;
            job.addr = 16'd0;
            phase_next = PH_ERASE_POLL;
          end
          PH_ERASE_POLL, PH_ERASE_RECHECK: begin
            post = 1'b1;
            job.addr = 16'd0;
            if (value == BLANK_BYTE) begin
              job.seq      = SEQ_STATUS;
              job.first_ev = EV_ERASE_DONE;
              phase_next   = PH_READY;
            end else if (phase == PH_ERASE_RECHECK) begin
              job.seq      = SEQ_ERASE;
              job.stop     = 3'd7;
              job.first_ev = EV_ERASE_RETRY;
              phase_next   = PH_ERASE_FIRST;
            end else if ((value & DQ5_MASK) != 8'd0) begin
              phase_next = PH_ERASE_RECHECK;
            end
          end
          PH_PROG_POLL, PH_PROG_RECHECK: begin
            post = 1'b1;
            if (value == pending_byte) begin
              job.seq    = SEQ_VERIFY;
              job.stop   = 3'd1;
              phase_next = PH_VERIFY;
            end else if (phase == PH_PROG_RECHECK) begin
              job.seq      = SEQ_PROG;
              job.stop     = 3'd6;
              job.first_ev = EV_PROG_RETRY;
              phase_next   = PH_PROG_POLL;
            end else if ((value & DQ5_MASK) != 8'd0) begin
              phase_next = PH_PROG_RECHECK;
            end
          end
          PH_VERIFY: begin
            post = 1'b1;
            if (value == pending_byte) begin
              good_bytes_next   = good_bytes + 16'd1;
              next_address_next = next_address + 16'd1;
              job.seq      = SEQ_STATUS;
              job.first_ev = EV_VERIFIED;
              job.count    = good_bytes + 16'd1;
              if (blank_run > blank_run_limit) begin
                job.stop   = 3'd1;
                phase_next = PH_DONE;
              end else begin
                phase_next = PH_READY;
              end
            end else begin
              job.seq      = SEQ_PROG;
              job.start    = 3'd1;
              job.stop     = 3'd6;
              job.first_ev = EV_VERIFY_RETRY;
              phase_next   = PH_PROG_POLL;
            end
          end
          default: post = 1'b0;
        endcase
      end
      default: post = 1'b0;
    endcase
  end

  assign push = accept && post;

  always_ff @(posedge clk) begin
    if (rst) begin
      blank_run_limit <= LIMIT_RESET;
      phase           <= PH_IDLE;
      next_address    <= 16'd0;
      pending_byte    <= 8'd0;
      blank_run       <= 8'd0;
      good_bytes      <= 16'd0;
    end else begin
      if (cfg_we) blank_run_limit <= cfg_data;
      if (accept) begin
        phase        <= phase_next;
        next_address <= next_address_next;
        pending_byte <= pending_byte_next;
        blank_run    <= blank_run_next;
        good_bytes   <= good_bytes_next;
      end
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/fesq_queue.sv */
// Short job queue between front and back end.
`default_nettype none
module fesq_queue import fesq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      full,
  output logic      nonempty,
  output job_t      head
);

`include "assert_macros.svh"

  job_t              slots [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QDEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + (QPTR_W+1)'(1);
      else if (pop && !push) count <= count - (QPTR_W+1)'(1);
    end
  end

  `ASSERT_ALWAYS(a_count_bound, clk, rst, count <= (QPTR_W+1)'(QDEPTH))
  `ASSERT_IMPLIES(a_no_push_full, clk, rst, push, !full)
  `ASSERT_IMPLIES(a_no_pop_empty, clk, rst, pop, nonempty)

endmodule
`default_nettype wire

/* hw/rtl/fesq_back.sv */
// Back end: plays out queued jobs as bus results, one per cycle while out_stall is low.
`default_nettype none
module fesq_back import fesq_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         q_nonempty,
  input  wire job_t         q_head,
  output logic              pop,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic [1:0]        op,
  output logic [15:0]       flash_address,
  output logic [7:0]        write_data,
  output logic [2:0]        event_res,
  output logic [15:0]       verified_count,
  output logic              last
);

`include "assert_macros.svh"

  job_t       cur;
  logic       active;
  logic [2:0] step;
  logic       load, finish;
  bus_t       res;

  assign load   = active && (!out_valid || !out_stall);
  assign finish = load && (step == cur.stop);
  assign pop    = q_nonempty && (!active || finish);
  assign res    = seq_step(cur.seq, step, cur.addr, cur.data);

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      step      <= 3'd0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        active <= 1'b1;
        step   <= q_head.start;
      end else if (finish) begin
        active <= 1'b0;
      end else if (load) begin
        step <= step + 3'd1;
      end
      if (load)            out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= q_head;
    if (load) begin
      op             <= res.op;
      flash_address  <= res.addr;
      write_data     <= res.data;
      event_res      <= (step == cur.start) ? cur.first_ev : res.ev;
      verified_count <= cur.count;
      last           <= (step == cur.stop);
    end
  end

  `ASSERT_IMPLIES(a_step_in_job, clk, rst, active, step <= cur.stop && step >= cur.start)
  `ASSERT_IMPLIES(a_load_needs_job, clk, rst, load, active)
  `ASSERT_IMPLIES(a_pop_when_free, clk, rst, pop, !active || finish)

endmodule
`default_nettype wire

/* dv/fesq_checker.sv */
`timescale 1ns / 1ps
// Checker for the flash sequencer: shadows the command flow and compares every result item.
module fesq_checker import fesq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [7:0]  value,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  op,
  input  logic [15:0] flash_address,
  input  logic [7:0]  write_data,
  input  logic [2:0]  event_res,
  input  logic [15:0] verified_count,
  input  logic        last,
  output int          fails,
  output int          pending
);

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] addr;
    logic [7:0]  data;
    logic [2:0]  ev;
    logic [15:0] cnt;
    logic        fin;
  } bus_op_t;

  bus_op_t     planned_ops[$];
  phase_t      ph;
  logic [15:0] nxt_addr;
  logic [7:0]  held_byte;
  logic [7:0]  ff_run;
  logic [7:0]  run_limit;
  logic [15:0] good_cnt;

  task automatic flag_mismatch(input string msg);
    fails++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic queue_op(input logic [1:0] o, input logic [15:0] a, input logic [7:0] d,
                          input logic [2:0] e);
    planned_ops.push_back('{op: o, addr: a, data: d, ev: e, cnt: good_cnt, fin: 1'b0});
  endtask

  task automatic queue_erase();
    queue_op(OP_WRITE, ADDR_555, CMD_UNLOCK1, EV_NONE);
    queue_op(OP_WRITE, ADDR_2AA, CMD_UNLOCK2, EV_NONE);
    queue_op(OP_WRITE, ADDR_555, CMD_ERASE, EV_NONE);
    queue_op(OP_WRITE, ADDR_555, CMD_UNLOCK1, EV_NONE);
    queue_op(OP_WRITE, ADDR_2AA, CMD_UNLOCK2, EV_NONE);
    queue_op(OP_WRITE, 16'h0000, CMD_SECTOR, EV_NONE);
    queue_op(OP_READ, 16'h0000, 8'h00, EV_NONE);
    ph = PH_ERASE_FIRST;
  endtask

  task automatic queue_program(input logic [2:0] e);
    queue_op(OP_WRITE, 16'h0000, CMD_RESET, e);
    queue_op(OP_WRITE, ADDR_555, CMD_UNLOCK1, EV_NONE);
    queue_op(OP_WRITE, ADDR_2AA, CMD_UNLOCK2, EV_NONE);
    queue_op(OP_WRITE, ADDR_555, CMD_PROGRAM, EV_NONE);
    queue_op(OP_WRITE, nxt_addr, held_byte, EV_NONE);
    queue_op(OP_READ, nxt_addr, 8'h00, EV_NONE);
    ph = PH_PROG_POLL;
  endtask

  task automatic queue_verify();
    queue_op(OP_WRITE, nxt_addr, CMD_RESET, EV_NONE);
    queue_op(OP_READ, nxt_addr, 8'h00, EV_NONE);
    ph = PH_VERIFY;
  endtask

  task automatic plan_bus_ops(input logic [1:0] k, input logic [7:0] v);
    int      was;
    bus_op_t tail;
    was = planned_ops.size();
    case (k)
      KIND_START: begin
        nxt_addr = '0;
        ff_run   = '0;
        good_cnt = '0;
        queue_erase();
      end
      KIND_BYTE: begin
        if (ph == PH_READY) begin
          if (v == BLANK_BYTE) begin
            if (ff_run != RUN_MAX) ff_run = ff_run + 8'd1;
          end else begin
            ff_run = '0;
          end
          held_byte = v;
          queue_program(EV_NONE);
        end
      end
      KIND_READ: begin
        case (ph)
          PH_ERASE_FIRST: begin
            queue_op(OP_READ, 16'h0000, 8'h00, EV_NONE);
            ph = PH_ERASE_POLL;
          end
          PH_ERASE_POLL: begin
            if (v == BLANK_BYTE) begin
              queue_op(OP_STATUS, 16'h0000, 8'h00, EV_ERASE_DONE);
              ph = PH_READY;
            end else begin
              queue_op(OP_READ, 16'h0000, 8'h00, EV_NONE);
              if ((v & DQ5_MASK) != 8'h00) ph = PH_ERASE_RECHECK;
            end
          end
          PH_ERASE_RECHECK: begin
            if (v == BLANK_BYTE) begin
              queue_op(OP_STATUS, 16'h0000, 8'h00, EV_ERASE_DONE);
              ph = PH_READY;
            end else begin
              queue_op(OP_WRITE, 16'h0000, CMD_RESET, EV_ERASE_RETRY);
              queue_erase();
            end
          end
          PH_PROG_POLL: begin
            if (v == held_byte) begin
              queue_verify();
            end else begin
              queue_op(OP_READ, nxt_addr, 8'h00, EV_NONE);
              if ((v & DQ5_MASK) != 8'h00) ph = PH_PROG_RECHECK;
            end
          end
          PH_PROG_RECHECK: begin
            if (v == held_byte) begin
              queue_verify();
            end else begin
              queue_op(OP_WRITE, nxt_addr, CMD_RESET, EV_PROG_RETRY);
              queue_program(EV_NONE);
            end
          end
          PH_VERIFY: begin
            if (v == held_byte) begin
              good_cnt = good_cnt + 16'd1;
              nxt_addr = nxt_addr + 16'd1;
              queue_op(OP_STATUS, 16'h0000, 8'h00, EV_VERIFIED);
              if (ff_run > run_limit) begin
                queue_op(OP_STATUS, 16'h0000, 8'h00, EV_IMAGE_END);
                ph = PH_DONE;
              end else begin
                ph = PH_READY;
              end
            end else begin
              queue_program(EV_VERIFY_RETRY);
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    // mark the final result of this item
    if (planned_ops.size() > was) begin
      tail = planned_ops.pop_back();
      tail.fin = 1'b1;
      planned_ops.push_back(tail);
    end
  endtask

  task automatic check_bus_op();
    bus_op_t got;
    bus_op_t want;
    got = '{op: op, addr: flash_address, data: write_data, ev: event_res,
            cnt: verified_count, fin: last};
    if (planned_ops.size() == 0) begin
      flag_mismatch($sformatf("unexpected item op %0d addr %h data %h ev %0d cnt %0d last %0d",
                              got.op, got.addr, got.data, got.ev, got.cnt, got.fin));
    end else begin
      want = planned_ops.pop_front();
      if (got.op !== want.op || got.addr !== want.addr || got.data !== want.data ||
          got.ev !== want.ev || got.cnt !== want.cnt || got.fin !== want.fin) begin
        flag_mismatch($sformatf(
          "got op %0d addr %h data %h ev %0d cnt %0d last %0d, want %0d %h %h %0d %0d %0d",
          got.op, got.addr, got.data, got.ev, got.cnt, got.fin,
          want.op, want.addr, want.data, want.ev, want.cnt, want.fin));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph        = PH_IDLE;
      nxt_addr  = '0;
      held_byte = '0;
      ff_run    = '0;
      good_cnt  = '0;
      run_limit = LIMIT_RESET;
      planned_ops.delete();
    end else begin
      if (cfg_we) run_limit = cfg_data;
      if (in_valid && !in_stall) plan_bus_ops(kind, value);
      if ($isunknown(out_valid)) flag_mismatch("out_valid unknown");
      else if (out_valid && !out_stall) check_bus_op();
    end
    pending = planned_ops.size();
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// Top of the flash sequencer testbench: clock, reset, stimulus and verdict.
module tb_top;
  import fesq_pkg::*;

  // kind code the block never decodes; must be dropped without results
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // generous ceiling on the whole run, in clock cycles
  localparam int CYCLE_LIMIT = 300000;
  // cycles the receiver holds off in the back-pressure stretch
  localparam int HOLD_CYCLES = 300;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        cfg_we    = 1'b0;
  logic [7:0]  cfg_data  = 8'h00;
  logic        in_valid  = 1'b0;
  logic [1:0]  kind      = KIND_START;
  logic [7:0]  value     = 8'h00;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [1:0]  op;
  logic [15:0] flash_address;
  logic [7:0]  write_data;
  logic [2:0]  event_res;
  logic [15:0] verified_count;
  logic        last;

  int fails;
  int pending;

  // stimulus bookkeeping
  int         sent       = 0;     // items accepted so far
  int         idle_pct   = 0;     // chance per item that the sender pauses
  int         stall_pct  = 0;     // chance per cycle that the receiver stalls
  int         hold_req   = 0;     // bumped by the stimulus to ask for a long hold
  int         hold_done  = 0;     // bumped by the receiver once a hold is over
  int         cycles     = 0;
  logic [7:0] limit_now  = LIMIT_RESET;
  logic [7:0] blank_run  = 8'h00; // consecutive blank image bytes, as the block sees it
  bit         image_done = 1'b0;

  flash_erase_program_sequencer_unit dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .op(op), .flash_address(flash_address),
    .write_data(write_data), .event_res(event_res), .verified_count(verified_count),
    .last(last)
  );

  fesq_checker chk (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .kind(kind), .value(value),
    .out_valid(out_valid), .out_stall(out_stall), .op(op), .flash_address(flash_address),
    .write_data(write_data), .event_res(event_res), .verified_count(verified_count),
    .last(last), .fails(fails), .pending(pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: a hung block or a lost item ends up here.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** flash_erase_program_sequencer_unit: FAILED **");
    $finish;
  end

  // Receiver. Random stall per cycle, or a long hold when asked for one;
  // the hold is counted here so the sender keeps offering items meanwhile.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req != hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done++;
      end else begin
        out_stall <= ($urandom_range(1, 100) <= stall_pct);
      end
    end
  end

  // Offer one item and wait for it to be taken. Called on a rising edge;
  // returns on the edge that accepted it, with valid still high.
  task automatic send_item(input logic [1:0] k, input logic [7:0] v);
    while ($urandom_range(1, 100) <= idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // Let every outstanding result drain. Ignored items leave nothing in the
  // checker's queue but may still be in flight, hence the extra pause.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_blank_limit(input logic [7:0] lim);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limit_now = lim;
  endtask

  // Start, then a plausible erase poll: busy bytes, DQ5 rechecks (some of
  // which fail and force a re-erase) and finally a blank read.
  task automatic run_erase();
    bit         ready;
    int         pick;
    logic [7:0] v;
    ready = 1'b0;
    send_item(KIND_START, 8'($urandom));
    blank_run  = 8'h00;
    image_done = 1'b0;
    send_item(KIND_READ, 8'($urandom));   // first read after the command is thrown away
    while (!ready) begin
      pick = $urandom_range(0, 19);
      if (pick < 2) begin
        // byte or unknown kind mid-erase: dropped
        send_item($urandom_range(0, 1) ? KIND_BYTE : KIND_UNUSED, 8'($urandom));
      end else if (pick < 9) begin
        send_item(KIND_READ, 8'($urandom) & ~DQ5_MASK);
      end else if (pick < 13) begin
        v = 8'($urandom) | DQ5_MASK;
        if (v == BLANK_BYTE) v = DQ5_MASK;
        send_item(KIND_READ, v);
        if ($urandom_range(0, 2) == 0) begin
          // recheck still not blank: reset and erase again
          send_item(KIND_READ, 8'($urandom_range(0, 254)));
          send_item(KIND_READ, 8'($urandom));
        end else begin
          send_item(KIND_READ, BLANK_BYTE);
          ready = 1'b1;
        end
      end else begin
        send_item(KIND_READ, BLANK_BYTE);
        ready = 1'b1;
      end
    end
  endtask

  // One image byte through program poll and verify, with retries of both
  // kinds and the odd abort by a fresh start.
  task automatic run_byte(input logic [7:0] b, output bit aborted);
    bit         verified;
    bit         matched;
    int         pick;
    logic [7:0] v;
    aborted  = 1'b0;
    verified = 1'b0;
    send_item(KIND_BYTE, b);
    if (b == BLANK_BYTE) begin
      if (blank_run != RUN_MAX) blank_run++;
    end else begin
      blank_run = 8'h00;
    end
    while (!verified && !aborted) begin
      matched = 1'b0;
      while (!matched && !aborted) begin
        pick = $urandom_range(0, 39);
        if (pick == 0) begin
          send_item(KIND_START, 8'($urandom));
          aborted = 1'b1;
        end else if (pick < 4) begin
          send_item($urandom_range(0, 1) ? KIND_BYTE : KIND_UNUSED, 8'($urandom));
        end else if (pick < 20) begin
          send_item(KIND_READ, b);
          matched = 1'b1;
        end else if (pick < 30) begin
          v = 8'($urandom) & ~DQ5_MASK;
          if (v == b) v ^= 8'h01;
          send_item(KIND_READ, v);
        end else begin
          v = 8'($urandom) | DQ5_MASK;
          if (v == b) v ^= 8'h01;
          send_item(KIND_READ, v);
          if ($urandom_range(0, 1)) begin
            send_item(KIND_READ, b);
            matched = 1'b1;
          end else begin
            // recheck wrong too: program timeout, byte goes again
            send_item(KIND_READ, b ^ 8'($urandom_range(1, 255)));
          end
        end
      end
      if (!aborted) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(KIND_READ, b ^ 8'($urandom_range(1, 255)));
        end else begin
          send_item(KIND_READ, b);
          verified = 1'b1;
        end
      end
    end
    if (verified && blank_run > limit_now) image_done = 1'b1;
  endtask

  // Erase plus a stream of bytes, half of them blank so the image ends now
  // and then; restarts after an end or an abort.
  task automatic run_session(input int budget);
    int stop_at;
    bit cut;
    stop_at = sent + budget;
    run_erase();
    while (sent < stop_at) begin
      if (image_done) begin
        send_item(KIND_BYTE, 8'($urandom));   // image over: dropped
        send_item(KIND_READ, 8'($urandom));   // no read outstanding: dropped
        run_erase();
      end else if ($urandom_range(0, 19) == 0) begin
        run_erase();
      end else if ($urandom_range(0, 9) == 0) begin
        send_item($urandom_range(0, 1) ? KIND_READ : KIND_UNUSED, 8'($urandom));
      end else begin
        run_byte($urandom_range(0, 1) ? BLANK_BYTE : 8'($urandom), cut);
        if (cut) run_erase();
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // ---- directed, at the reset limit ----
    send_item(KIND_BYTE, 8'h5A);         // byte before any erase: dropped
    send_item(KIND_READ, 8'h00);         // read with none pending: dropped
    send_item(KIND_UNUSED, BLANK_BYTE);  // unknown kind: dropped
    send_item(KIND_START, 8'h00);
    send_item(KIND_READ, 8'h12);         // discarded first read
    send_item(KIND_READ, 8'h00);         // busy, DQ5 clear
    send_item(KIND_READ, 8'h20);         // DQ5 set: recheck
    send_item(KIND_READ, 8'h00);         // still busy: reset and re-erase
    send_item(KIND_READ, BLANK_BYTE);    // discarded, even though blank
    send_item(KIND_READ, 8'h7F);         // DQ5 set: recheck
    send_item(KIND_READ, BLANK_BYTE);    // recheck passes: erase done
    send_item(KIND_READ, 8'h33);         // ready, no read pending: dropped
    send_item(KIND_BYTE, 8'h00);
    send_item(KIND_READ, BLANK_BYTE);    // wrong with DQ5: recheck
    send_item(KIND_READ, 8'h80);         // still wrong: program timeout retry
    send_item(KIND_READ, 8'h01);         // wrong, DQ5 clear
    send_item(KIND_READ, 8'h20);         // wrong with DQ5: recheck
    send_item(KIND_READ, 8'h00);         // matches: verify
    send_item(KIND_READ, BLANK_BYTE);    // verify mismatch: reprogram
    send_item(KIND_READ, 8'h00);
    send_item(KIND_BYTE, 8'h77);         // byte while one is in flight: dropped
    send_item(KIND_READ, 8'h00);         // verified, count 1

    // image end at once with a zero limit, then items after the end
    set_blank_limit(8'd0);
    send_item(KIND_BYTE, BLANK_BYTE);
    send_item(KIND_READ, BLANK_BYTE);
    send_item(KIND_READ, BLANK_BYTE);    // verified and image ended
    send_item(KIND_BYTE, 8'h10);
    send_item(KIND_READ, 8'h10);

    // ---- random, one stretch per idling pattern ----
    set_blank_limit(8'd1);
    idle_pct  = 0;
    stall_pct = 0;
    run_session(24);

    set_blank_limit(8'd3);
    idle_pct  = 53;
    stall_pct = 0;
    run_session(24);

    // long receiver hold while the sender keeps pushing: fills the block
    set_blank_limit(8'd0);
    idle_pct  = 0;
    stall_pct = 53;
    hold_req++;
    run_session(24);

    set_blank_limit(8'($urandom_range(2, 6)));
    idle_pct  = 17;
    stall_pct = 17;
    run_session(24);

    drain();
    repeat (20) @(posedge clk);
    if (fails == 0) begin
      $display("** flash_erase_program_sequencer_unit: PASSED **");
    end else begin
      $display("** flash_erase_program_sequencer_unit: FAILED **");
    end
    $finish;
  end

endmodule
